[rtl/core/slmr_pkg.sv]
// Shared types and constants for the scrolling LED matrix refresh block.
// No dependencies; imported by the top level and its port checker.
package slmr_pkg;

    // Display and message geometry
    localparam int MSG_DEPTH   = 64;
    localparam int NUM_ROWS    = 7;
    localparam int NUM_DIGITS  = 4;
    localparam int CHAR_OFFSET = 32;
    localparam int BLANK_GLYPH = 0;

    // Derived widths
    localparam int MSG_AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int LEN_W  = $clog2(MSG_DEPTH + 1);
    localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int DIG_W  = $clog2(NUM_DIGITS);

    // Field widths
    localparam int PERIOD_W = 16;
    localparam int MLEN_W   = 7;
    localparam int WIDX_W   = 6;
    localparam int CHAR_W   = 8;
    localparam int ROWF_W   = 3;
    localparam int ANODE_W  = 7;

    // Input beat: write_index in the low bits, write_char above it
    localparam int S_DATA_W  = 16;
    localparam int WIDX_LO   = 0;
    localparam int WCHAR_LO  = WIDX_LO + WIDX_W;

    // Output beat: four glyphs, row, anode, scrolled flag
    localparam int GLYPH_LO  = 0;
    localparam int ROWF_LO   = GLYPH_LO + 4 * CHAR_W;
    localparam int ANODE_LO  = ROWF_LO + ROWF_W;
    localparam int SCROLL_LO = ANODE_LO + ANODE_W;
    localparam int M_FIELD_W = SCROLL_LO + 1;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCROLL_PERIOD  = 1'b0,
        CFG_MESSAGE_LENGTH = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // Character code to glyph code, wrapping modulo 256
    function automatic logic [CHAR_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
        glyph_of = c - CHAR_W'(CHAR_OFFSET);
    endfunction

endpackage

[rtl/core/slmr_msg_ram.sv]
// Simple dual-port message RAM: one write port, one registered read port.
// Generic; depends on nothing else.
module slmr_msg_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/scrolling_led_matrix_refresh.sv]
// Scrolling LED matrix refresh: top level.
// Depends on slmr_pkg and slmr_msg_ram.
//
// A beat with tuser = 1 stores one message character; a beat with tuser = 0 is a
// refresh tick and yields one output beat with the four glyph codes, the row being
// driven, its one-hot anode and a reload flag. Writes and ticks that do not reload
// may follow one another on every cycle while the output is taken. An output beat
// that waits holds the input off until it leaves. The next beat may be taken in
// the same cycle as the waiting one leaves. A tick that reaches the scroll period
// reloads the four glyphs from the message RAM through its single read port, one
// digit a cycle, and holds the input off through the accepting cycle, four reads,
// and a final step in which the last read returns and the output beat is loaded.
// The message RAM has no reset: a character slot must be written before the message
// length covers it.
module scrolling_led_matrix_refresh
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [slmr_pkg::S_DATA_W-1:0]     s_tdata,   // write_index[5:0], write_char[13:6]
    input  logic                              s_tuser,   // op (0 tick, 1 write)
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [slmr_pkg::M_DATA_W-1:0]     m_tdata,   // glyph_first[7:0], glyph_second[15:8],
                                                         // glyph_third[23:16], glyph_fourth[31:24],
                                                         // row_index[34:32], anode_select[41:35],
                                                         // scrolled[42]
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slmr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slmr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import slmr_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_READ,
        ST_LAST
    } state_t;

    state_t               state_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [MLEN_W-1:0]    mlen_reg;
    logic [PERIOD_W-1:0]  tick_reg;
    logic [MSG_AW-1:0]    pos_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_hold_reg;
    logic [CHAR_W-1:0]    shown_reg [NUM_DIGITS];
    logic [MSG_AW-1:0]    rd_addr_reg;
    logic [DIG_W-1:0]     dig_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic [LEN_W-1:0]     len_eff;
    logic                 out_free;
    logic                 s_acc;
    logic                 is_write;
    logic [PERIOD_W-1:0]  tick_next;
    logic                 reload;
    logic [MSG_AW-1:0]    pos_start;
    logic [MSG_AW-1:0]    pos_next;
    logic [ROW_W-1:0]     row_next;
    logic [WIDX_W-1:0]    wr_index;
    logic [CHAR_W-1:0]    wr_char;
    logic                 ram_we;
    logic                 ram_re;
    logic [CHAR_W-1:0]    ram_rdata;
    logic                 cap_en;
    logic [DIG_W-1:0]     cap_idx;
    logic [CHAR_W-1:0]    cap_glyph;
    logic                 beat_load;

    // Next slot of the circular message
    function automatic logic [MSG_AW-1:0] next_slot(input logic [MSG_AW-1:0] a,
                                                     input logic [LEN_W-1:0]  len);
        logic [LEN_W-1:0] inc;
        inc = LEN_W'(a) + LEN_W'(1);
        next_slot = (inc == len) ? '0 : MSG_AW'(inc);
    endfunction

    // Pack one output beat
    function automatic logic [M_DATA_W-1:0] pack_beat(input logic [CHAR_W-1:0] g0,
                                                       input logic [CHAR_W-1:0] g1,
                                                       input logic [CHAR_W-1:0] g2,
                                                       input logic [CHAR_W-1:0] g3,
                                                       input logic [ROW_W-1:0]  row,
                                                       input logic              scr);
        logic [ANODE_W-1:0] anode;
        anode     = ANODE_W'(1) << row;
        pack_beat = M_DATA_W'({scr, anode, ROWF_W'(row), g3, g2, g1, g0});
    endfunction

    // Unpack the input beat
    assign wr_index = s_tdata[WIDX_LO +: WIDX_W];
    assign wr_char  = s_tdata[WCHAR_LO +: CHAR_W];
    assign is_write = (s_tuser == OP_WRITE);

    // Handshakes
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_RUN) && out_free;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Effective length saturates at the store depth
    assign len_eff = (32'(mlen_reg) > MSG_DEPTH) ? LEN_W'(MSG_DEPTH) : LEN_W'(mlen_reg);

    // Tick counting and reload decision
    assign tick_next = tick_reg + PERIOD_W'(1);
    assign reload    = (tick_next >= period_reg);

    // Scroll position: restart when past the length, advance for long messages
    assign pos_start = (LEN_W'(pos_reg) >= len_eff) ? '0 : pos_reg;
    assign pos_next  = (32'(len_eff) > NUM_DIGITS) ? next_slot(pos_start, len_eff) : pos_start;

    // Row steps modulo the row count
    assign row_next = (32'(row_reg) + 1 >= NUM_ROWS) ? '0 : ROW_W'(row_reg + ROW_W'(1));

    // Message RAM access
    assign ram_we = s_acc && is_write && (32'(wr_index) < MSG_DEPTH);
    assign ram_re = (state_reg == ST_READ);

    slmr_msg_ram #(
        .DEPTH (MSG_DEPTH),
        .WIDTH (CHAR_W)
    ) u_msg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (MSG_AW'(wr_index)),
        .wdata (wr_char),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Capture read data in the cycle after each read; digits past the length go blank
    assign cap_en    = ((state_reg == ST_READ) && (dig_reg != '0)) || (state_reg == ST_LAST);
    assign cap_idx   = (state_reg == ST_LAST) ? DIG_W'(NUM_DIGITS - 1) : dig_reg - DIG_W'(1);
    assign cap_glyph = (LEN_W'(cap_idx) < len_eff) ? glyph_of(ram_rdata)
                                                   : CHAR_W'(BLANK_GLYPH);

    // Load an output beat for a plain tick or at the end of a reload
    assign beat_load = (s_acc && !is_write && !reload) || (state_reg == ST_LAST);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_W'(100);
            mlen_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCROLL_PERIOD:  period_reg <= cfg_data;
                CFG_MESSAGE_LENGTH: mlen_reg   <= MLEN_W'(cfg_data);
                default:            ;
            endcase
        end
    end

    // Sequencer, counters, shown glyphs and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            tick_reg     <= '0;
            pos_reg      <= '0;
            row_reg      <= '0;
            row_hold_reg <= '0;
            rd_addr_reg  <= '0;
            dig_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                shown_reg[k] <= CHAR_W'(BLANK_GLYPH);
            end
        end
        else
        begin
            // Raise valid for a new beat, drop it once the current one is taken
            if (beat_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // Store a captured glyph
            if (cap_en)
            begin
                shown_reg[cap_idx] <= cap_glyph;
            end

            case (state_reg)
                ST_RUN:
                begin
                    if (s_acc && !is_write)
                    begin
                        row_reg <= row_next;
                        if (reload)
                        begin
                            tick_reg     <= '0;
                            pos_reg      <= pos_next;
                            rd_addr_reg  <= pos_start;
                            dig_reg      <= '0;
                            row_hold_reg <= row_reg;
                            state_reg    <= ST_READ;
                        end
                        else
                        begin
                            tick_reg     <= tick_next;
                            m_tdata_reg  <= pack_beat(shown_reg[0], shown_reg[1],
                                                      shown_reg[2], shown_reg[3],
                                                      row_reg, 1'b0);
                        end
                    end
                end

                ST_READ:
                begin
                    // Advance through the circular message, one digit a cycle
                    rd_addr_reg <= next_slot(rd_addr_reg, len_eff);
                    dig_reg     <= dig_reg + DIG_W'(1);
                    if (dig_reg == DIG_W'(NUM_DIGITS - 1))
                    begin
                        state_reg <= ST_LAST;
                    end
                end

                ST_LAST:
                begin
                    // Last glyph arrives now; emit the reloaded beat
                    m_tdata_reg  <= pack_beat(shown_reg[0], shown_reg[1], shown_reg[2],
                                              cap_glyph, row_hold_reg, 1'b1);
                    state_reg    <= ST_RUN;
                end

                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

endmodule

[rtl/core/slmr_checker.sv]
// Port-level checker for the scrolling LED matrix refresh block, with its bind.
// Depends on slmr_pkg; attaches to scrolling_led_matrix_refresh.
module slmr_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [slmr_pkg::M_DATA_W-1:0]     m_tdata
);

    import slmr_pkg::*;

    logic [ROWF_W-1:0]  beat_row;
    logic [ANODE_W-1:0] beat_anode;

    assign beat_row   = m_tdata[ROWF_LO +: ROWF_W];
    assign beat_anode = m_tdata[ANODE_LO +: ANODE_W];

    // Anode lights exactly the driven row
    a_anode_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(beat_anode) && (beat_anode == (ANODE_W'(1) << beat_row)))
        else $error("anode does not match row");

    // Row stays within the matrix
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(beat_row) < NUM_ROWS))
        else $error("row index out of range");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // A character write yields no output beat
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("write produced an output beat");

endmodule

bind scrolling_led_matrix_refresh slmr_checker u_slmr_checker (.*);
